[rtl/aac_pkg.sv]
// Shared widths, register map, reset values and stage types for the ARGB compositor.
package aac_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int DIM_W       = 13;
    localparam int OFS_W       = 14;
    localparam int PIX_W       = 32;
    localparam int IDX_W       = 24;
    localparam int CFG_W       = 32;
    localparam int ADDR_W      = 5;
    localparam int IN_W        = 2 * PIX_W;
    localparam int OUT_W       = 56;

    localparam logic [DIM_W-1:0] LOWER_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] LOWER_HEIGHT_RST = 13'd480;
    localparam logic [DIM_W-1:0] UPPER_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] UPPER_HEIGHT_RST = 13'd480;
    localparam logic [OFS_W-1:0] OFFSET_RST       = 14'd0;

    typedef enum logic [2:0] {
        REG_LOWER_WIDTH  = 3'd0,
        REG_LOWER_HEIGHT = 3'd1,
        REG_UPPER_WIDTH  = 3'd2,
        REG_UPPER_HEIGHT = 3'd3,
        REG_OFFSET_X     = 3'd4,
        REG_OFFSET_Y     = 3'd5
    } t_reg_idx;

    // Position of one pixel in the lower frame, handed from the raster stage to the blend stage.
    typedef struct packed {
        logic             in_frame;
        logic             last;
        logic [DIM_W-1:0] lx;
        logic [DIM_W-1:0] ly;
        logic [DIM_W-1:0] lw;
    } t_pos;

endpackage

[rtl/argb_alpha_compositor_unit.sv]
// Top level of the ARGB8888 source-over compositor with raster tracking and clipping.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: upper_pixel[31:0], lower_pixel[63:32]
//  m_axis    out        tdata: blended_pixel, lower_index; tuser: write_enable; tlast: frame_last
//  apb       in/out     six registers at 4*i: lower/upper width and height, offset x, offset y
//
// One beat is accepted per clock while m_axis is ready; results pass both register stages.
// The raster counter update and clipping sit in the first register stage, the 8x8 channel
// products and the row-by-width index multiply in the second.
// Synchronous active-low reset clears the counters, valid flags and registers to their defaults.
// A stall on m_axis holds the result register and backs up through both stages to s_axis.
module argb_alpha_compositor_unit #(
    parameter int MAX_DIM = aac_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [aac_pkg::IN_W-1:0]      s_axis_tdata,  // upper_pixel, lower_pixel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [aac_pkg::OUT_W-1:0]     m_axis_tdata,  // blended_pixel, lower_index
    output logic                          m_axis_tuser,  // write_enable
    output logic                          m_axis_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aac_pkg::ADDR_W-1:0]    paddr,
    input  logic [aac_pkg::CFG_W-1:0]     pwdata,
    output logic [aac_pkg::CFG_W-1:0]     prdata,
    output logic                          pready
);

    logic [aac_pkg::DIM_W-1:0] r_lower_width, r_lower_height, r_upper_width, r_upper_height;
    logic [aac_pkg::OFS_W-1:0] r_offset_x, r_offset_y;
    logic                      cfg_wr;
    aac_pkg::t_reg_idx         reg_sel;

    logic                      st_valid, st_ready;
    logic [aac_pkg::PIX_W-1:0] st_upper, st_lower;
    aac_pkg::t_pos             st_pos;
    logic [aac_pkg::PIX_W-1:0] res_pixel;
    logic [aac_pkg::IDX_W-1:0] res_index;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = aac_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_width  <= aac_pkg::LOWER_WIDTH_RST;
            r_lower_height <= aac_pkg::LOWER_HEIGHT_RST;
            r_upper_width  <= aac_pkg::UPPER_WIDTH_RST;
            r_upper_height <= aac_pkg::UPPER_HEIGHT_RST;
            r_offset_x     <= aac_pkg::OFFSET_RST;
            r_offset_y     <= aac_pkg::OFFSET_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                aac_pkg::REG_LOWER_WIDTH:  r_lower_width  <= pwdata[aac_pkg::DIM_W-1:0];
                aac_pkg::REG_LOWER_HEIGHT: r_lower_height <= pwdata[aac_pkg::DIM_W-1:0];
                aac_pkg::REG_UPPER_WIDTH:  r_upper_width  <= pwdata[aac_pkg::DIM_W-1:0];
                aac_pkg::REG_UPPER_HEIGHT: r_upper_height <= pwdata[aac_pkg::DIM_W-1:0];
                aac_pkg::REG_OFFSET_X:     r_offset_x     <= pwdata[aac_pkg::OFS_W-1:0];
                aac_pkg::REG_OFFSET_Y:     r_offset_y     <= pwdata[aac_pkg::OFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            aac_pkg::REG_LOWER_WIDTH:  prdata = aac_pkg::CFG_W'(r_lower_width);
            aac_pkg::REG_LOWER_HEIGHT: prdata = aac_pkg::CFG_W'(r_lower_height);
            aac_pkg::REG_UPPER_WIDTH:  prdata = aac_pkg::CFG_W'(r_upper_width);
            aac_pkg::REG_UPPER_HEIGHT: prdata = aac_pkg::CFG_W'(r_upper_height);
            aac_pkg::REG_OFFSET_X:     prdata = aac_pkg::CFG_W'(r_offset_x);
            aac_pkg::REG_OFFSET_Y:     prdata = aac_pkg::CFG_W'(r_offset_y);
            default:                   prdata = '0;
        endcase
    end

    aac_raster #(
        .MAX_DIM(MAX_DIM)
    ) u_raster (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_upper        (s_axis_tdata[aac_pkg::PIX_W-1:0]),
        .i_lower        (s_axis_tdata[aac_pkg::IN_W-1:aac_pkg::PIX_W]),
        .i_lower_width  (r_lower_width),
        .i_lower_height (r_lower_height),
        .i_upper_width  (r_upper_width),
        .i_upper_height (r_upper_height),
        .i_offset_x     (r_offset_x),
        .i_offset_y     (r_offset_y),
        .o_valid        (st_valid),
        .i_ready        (st_ready),
        .o_upper        (st_upper),
        .o_lower        (st_lower),
        .o_pos          (st_pos)
    );

    aac_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (st_valid),
        .o_ready        (st_ready),
        .i_upper        (st_upper),
        .i_lower        (st_lower),
        .i_pos          (st_pos),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_pixel        (res_pixel),
        .o_index        (res_index),
        .o_write_enable (m_axis_tuser),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {res_index, res_pixel};

endmodule

[rtl/aac_raster.sv]
// Raster position counters, lower-frame clipping and the input register stage.
module aac_raster #(
    parameter int MAX_DIM = aac_pkg::MAX_DIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [aac_pkg::PIX_W-1:0]   i_upper,
    input  logic [aac_pkg::PIX_W-1:0]   i_lower,
    input  logic [aac_pkg::DIM_W-1:0]   i_lower_width,
    input  logic [aac_pkg::DIM_W-1:0]   i_lower_height,
    input  logic [aac_pkg::DIM_W-1:0]   i_upper_width,
    input  logic [aac_pkg::DIM_W-1:0]   i_upper_height,
    input  logic [aac_pkg::OFS_W-1:0]   i_offset_x,
    input  logic [aac_pkg::OFS_W-1:0]   i_offset_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [aac_pkg::PIX_W-1:0]   o_upper,
    output logic [aac_pkg::PIX_W-1:0]   o_lower,
    output aac_pkg::t_pos               o_pos
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int POS_W = ((CW > aac_pkg::OFS_W) ? CW : aac_pkg::OFS_W) + 2;
    localparam int DW    = aac_pkg::DIM_W;

    function automatic logic [DW-1:0] dim_eff(input logic [DW-1:0] v);
        if (v == '0) begin
            return DW'(1);
        end
        if (32'(v) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end
        return v;
    endfunction

    logic [CW-1:0]             r_col, r_row;
    logic                      r_valid;
    logic [aac_pkg::PIX_W-1:0] r_upper, r_lower;
    aac_pkg::t_pos             r_pos;

    logic [DW-1:0]             lw_eff, lh_eff, uw_eff, uh_eff;
    logic signed [POS_W-1:0]   lx, ly;
    logic                      x_in, y_in, col_wrap, row_wrap, accept;
    logic [CW:0]               col_inc, row_inc;
    logic [CW-1:0]             n_col, n_row;
    aac_pkg::t_pos             n_pos;

    assign lw_eff = dim_eff(i_lower_width);
    assign lh_eff = dim_eff(i_lower_height);
    assign uw_eff = dim_eff(i_upper_width);
    assign uh_eff = dim_eff(i_upper_height);

    assign lx = $signed(POS_W'(r_col)) + POS_W'($signed(i_offset_x));
    assign ly = $signed(POS_W'(r_row)) + POS_W'($signed(i_offset_y));

    assign x_in = !lx[POS_W-1] && (lx[POS_W-2:0] < (POS_W-1)'(lw_eff));
    assign y_in = !ly[POS_W-1] && (ly[POS_W-2:0] < (POS_W-1)'(lh_eff));

    assign col_inc  = {1'b0, r_col} + (CW+1)'(1);
    assign row_inc  = {1'b0, r_row} + (CW+1)'(1);
    assign col_wrap = POS_W'(col_inc) >= POS_W'(uw_eff);
    assign row_wrap = POS_W'(row_inc) >= POS_W'(uh_eff);

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_pos.in_frame = x_in && y_in;
        n_pos.last     = col_wrap && row_wrap;
        n_pos.lx       = lx[DW-1:0];
        n_pos.ly       = ly[DW-1:0];
        n_pos.lw       = lw_eff;
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : row_inc[CW-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_upper <= i_upper;
            r_lower <= i_lower;
            r_pos   <= n_pos;
        end
    end

    assign o_valid = r_valid;
    assign o_upper = r_upper;
    assign o_lower = r_lower;
    assign o_pos   = r_pos;

endmodule

[rtl/aac_blend.sv]
// Source-over blend, lower-frame index and the result register stage.
module aac_blend (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [aac_pkg::PIX_W-1:0]   i_upper,
    input  logic [aac_pkg::PIX_W-1:0]   i_lower,
    input  aac_pkg::t_pos               i_pos,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [aac_pkg::PIX_W-1:0]   o_pixel,
    output logic [aac_pkg::IDX_W-1:0]   o_index,
    output logic                        o_write_enable,
    output logic                        o_last
);

    localparam int DW = aac_pkg::DIM_W;

    // Approximates c*a/255 as ((c*a + 128) * 257) >> 16.
    function automatic logic [8:0] scale255(input logic [7:0] c, input logic [7:0] a);
        logic [16:0] t;
        logic [24:0] s;
        t = ({9'b0, c} * {9'b0, a}) + 17'd128;
        s = {8'b0, t} + {t, 8'b0};
        return s[24:16];
    endfunction

    logic                      r_valid, r_we, r_last;
    logic [aac_pkg::PIX_W-1:0] r_pixel;
    logic [aac_pkg::IDX_W-1:0] r_index;

    logic [7:0]                ua, la, ia;
    logic [9:0]                sum;
    logic [aac_pkg::PIX_W-1:0] mix, n_pixel;
    logic [2*DW-1:0]           idx_full;
    logic                      load;

    assign ua = i_upper[31:24];
    assign la = i_lower[31:24];
    assign ia = 8'd255 - ua;

    always_comb begin
        mix = '0;
        for (int ch = 0; ch < 3; ch++) begin
            sum = 10'(scale255(i_upper[8*ch +: 8], ua)) + 10'(scale255(i_lower[8*ch +: 8], ia));
            mix[8*ch +: 8] = sum[7:0];
        end
        sum = 10'(ua) + 10'(scale255(la, ia));
        mix[31:24] = sum[7:0];

        if (!i_pos.in_frame) begin
            n_pixel = '0;
        end else if (ua == 8'hFF || la == 8'h00) begin
            n_pixel = i_upper;
        end else if (ua == 8'h00) begin
            n_pixel = i_lower;
        end else begin
            n_pixel = mix;
        end
    end

    assign idx_full = ((2*DW)'(i_pos.ly) * (2*DW)'(i_pos.lw)) + (2*DW)'(i_pos.lx);

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pixel <= n_pixel;
            r_index <= i_pos.in_frame ? idx_full[aac_pkg::IDX_W-1:0] : '0;
            r_we    <= i_pos.in_frame;
            r_last  <= i_pos.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_pixel        = r_pixel;
    assign o_index        = r_index;
    assign o_write_enable = r_we;
    assign o_last         = r_last;

endmodule
